/* sv/ls3_pkg.sv */
// Shared widths, constants and the queue entry type of the 3x3 solver.
`timescale 1ns / 1ps
`default_nettype none
package ls3_pkg;

  localparam int unsigned IN_W     = 32;
  localparam int unsigned XW       = 32;
  localparam int unsigned QW       = 32;
  localparam int unsigned MAG_W    = 98;
  localparam int unsigned DW       = MAG_W + 1;
  localparam int unsigned RW       = MAG_W + 34;
  localparam int unsigned TOL_W    = 63;
  localparam logic [TOL_W-1:0] TOL_RESET = 63'd281475;
  localparam logic [XW-1:0] X_MAX  = 32'h7FFF_FFFF;
  localparam logic [XW-1:0] X_MIN  = 32'h8000_0000;

  localparam int unsigned QDEPTH   = 4;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [2:0][RW-1:0] n;
    logic [DW-1:0]      d;
    logic [2:0]         neg;
    logic               solved;
  } ls3_job_t;

endpackage
`default_nettype wire

/* sv/ls3_front.sv */
// Front pipeline: cofactors, determinant, numerators and singular check.
`timescale 1ns / 1ps
`default_nettype none
module ls3_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic [8:0][ls3_pkg::IN_W-1:0]          a_i,
  input  wire logic [2:0][ls3_pkg::IN_W-1:0]          b_i,
  input  wire logic [ls3_pkg::TOL_W-1:0]              tol_i,
  output logic                                        job_valid_o,
  input  wire logic                                   job_ready_i,
  output ls3_pkg::ls3_job_t                           job_o
);

  localparam int unsigned FS = 7;
  localparam int unsigned MW = ls3_pkg::MAG_W;
  localparam int unsigned RW = ls3_pkg::RW;
  localparam int unsigned DW = ls3_pkg::DW;

  localparam int unsigned COF_IDX [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };
  localparam int unsigned TM [12] = '{0, 1, 2, 3, 4, 5, 3, 4, 5, 3, 4, 5};
  localparam int unsigned TK [12] = '{0, 3, 6, 0, 1, 2, 3, 4, 5, 6, 7, 8};

  logic [FS-1:0] v_q;
  logic          en;

  logic signed [63:0]   pp_q [9][2];
  logic signed [63:0]   pp_d [9][2];
  logic [5:0][31:0]     m1_q, m2_q;
  logic signed [64:0]   cof_q [9];
  logic signed [64:0]   cof_d [9];
  logic signed [64:0]   plo_q [12], phi_q [12];
  logic signed [64:0]   plo_d [12], phi_d [12];
  logic signed [MW-1:0] term_q [12];
  logic signed [MW-1:0] term_d [12];
  logic signed [MW-1:0] det_q, det_d;
  logic signed [MW-1:0] num_q [3];
  logic signed [MW-1:0] num_d [3];
  logic [MW-1:0]        dmag_q, dmag_d;
  logic [MW-1:0]        nmag_q [3];
  logic [MW-1:0]        nmag_d [3];
  logic [2:0]           neg_q, neg_d;
  ls3_pkg::ls3_job_t    job_q, job_d;

  assign en          = !(v_q[FS-1] && !job_ready_i);
  assign in_stall_o  = !en;
  assign job_valid_o = v_q[FS-1];
  assign job_o       = job_q;

  always_comb begin
    logic signed [31:0] ms;
    logic signed [32:0] lo_s;
    logic signed [32:0] hi_s;
    for (int k = 0; k < 9; k++) begin
      pp_d[k][0] = $signed(a_i[COF_IDX[k][0]]) * $signed(a_i[COF_IDX[k][1]]);
      pp_d[k][1] = $signed(a_i[COF_IDX[k][2]]) * $signed(a_i[COF_IDX[k][3]]);
      cof_d[k]   = 65'(pp_q[k][0]) - 65'(pp_q[k][1]);
    end
    for (int t = 0; t < 12; t++) begin
      ms        = $signed(m2_q[TM[t]]);
      lo_s      = $signed({1'b0, cof_q[TK[t]][31:0]});
      hi_s      = $signed(cof_q[TK[t]][64:32]);
      plo_d[t]  = ms * lo_s;
      phi_d[t]  = ms * hi_s;
      term_d[t] = (MW'(phi_q[t]) <<< 32) + MW'(plo_q[t]);
    end
    det_d = term_q[0] + term_q[1] + term_q[2];
    for (int r = 0; r < 3; r++) begin
      num_d[r]  = term_q[3+3*r] + term_q[4+3*r] + term_q[5+3*r];
      nmag_d[r] = num_q[r][MW-1] ? MW'(-num_q[r]) : MW'(num_q[r]);
      neg_d[r]  = num_q[r][MW-1] ^ det_q[MW-1];
      job_d.n[r] = (RW'(nmag_q[r]) << (FRAC_BITS + 1)) + RW'(dmag_q);
    end
    dmag_d       = det_q[MW-1] ? MW'(-det_q) : MW'(det_q);
    job_d.d      = {dmag_q, 1'b0};
    job_d.neg    = neg_q;
    job_d.solved = (dmag_q != '0) && (dmag_q >= MW'(tol_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[FS-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pp_q   <= pp_d;
      m1_q   <= {b_i, a_i[2], a_i[1], a_i[0]};
      m2_q   <= m1_q;
      cof_q  <= cof_d;
      plo_q  <= plo_d;
      phi_q  <= phi_d;
      term_q <= term_d;
      det_q  <= det_d;
      num_q  <= num_d;
      dmag_q <= dmag_d;
      nmag_q <= nmag_d;
      neg_q  <= neg_d;
      job_q  <= job_d;
    end
  end

endmodule
`default_nettype wire

/* sv/ls3_queue.sv */
// Short register queue between the front and back pipelines.
`timescale 1ns / 1ps
`default_nettype none
module ls3_queue (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push_valid_i,
  output logic                   push_ready_o,
  input  wire ls3_pkg::ls3_job_t push_data_i,
  output logic                   pop_valid_o,
  input  wire logic              pop_ready_i,
  output ls3_pkg::ls3_job_t      pop_data_o
);

  ls3_pkg::ls3_job_t                mem_q [ls3_pkg::QDEPTH];
  logic [ls3_pkg::QPTR_W-1:0]       wr_q, rd_q;
  logic [ls3_pkg::QCNT_W-1:0]       cnt_q;
  logic                             push, pop;

  assign push_ready_o = (cnt_q != ls3_pkg::QCNT_W'(ls3_pkg::QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= ls3_pkg::QCNT_W'(ls3_pkg::QDEPTH))
    else $error("queue count above depth");

  a_cnt_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count missed a push");

endmodule
`default_nettype wire

/* sv/ls3_div.sv */
// One lane of the pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module ls3_div (
  input  wire logic                    clk_i,
  input  wire logic                    en_i,
  input  wire logic [ls3_pkg::RW-1:0]  n_i,
  input  wire logic [ls3_pkg::DW-1:0]  d_i,
  output logic [ls3_pkg::QW-1:0]       q_o,
  output logic                         ovf_o
);

  localparam int unsigned RW = ls3_pkg::RW;
  localparam int unsigned QW = ls3_pkg::QW;

  logic [RW-1:0] rem_q [QW+1];
  logic [RW-1:0] dd_q  [QW+1];
  logic [QW-1:0] q_q   [QW+1];
  logic          ovf_q [QW+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= n_i;
      dd_q[0]  <= RW'(d_i);
      q_q[0]   <= '0;
      ovf_q[0] <= n_i >= (RW'(d_i) << QW);
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [RW-1:0] sh;
    logic          ge;
    assign sh = dd_q[k] << (QW - 1 - k);
    assign ge = rem_q[k] >= sh;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= ge ? rem_q[k] - sh : rem_q[k];
        dd_q[k+1]  <= dd_q[k];
        q_q[k+1]   <= q_q[k] | (QW'(ge) << (QW - 1 - k));
        ovf_q[k+1] <= ovf_q[k];
      end
    end
  end

  assign q_o   = q_q[QW];
  assign ovf_o = ovf_q[QW];

endmodule
`default_nettype wire

/* sv/ls3_back.sv */
// Back pipeline: three divider lanes, saturation limits and the output register.
`timescale 1ns / 1ps
`default_nettype none
module ls3_back (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   job_valid_i,
  output logic                        job_ready_o,
  input  wire ls3_pkg::ls3_job_t      job_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [2:0][ls3_pkg::XW-1:0] x_o,
  output logic                        solved_o,
  output logic                        clipped_o
);

  localparam int unsigned QW = ls3_pkg::QW;
  localparam int unsigned XW = ls3_pkg::XW;
  localparam int unsigned BS = QW + 2;

  logic [BS-1:0]          v_q;
  logic                   en;
  logic [2:0]             neg_q    [QW+1];
  logic                   solved_q [QW+1];
  logic [2:0][QW-1:0]     q;
  logic [2:0]             ovf;
  logic [2:0][XW-1:0]     x_d, x_q;
  logic [2:0]             clip;
  logic                   solved_out_q, clipped_q;

  assign en          = !(v_q[BS-1] && out_stall_i);
  assign job_ready_o = en;

  for (genvar r = 0; r < 3; r++) begin : g_lane
    ls3_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .n_i   (job_i.n[r]),
      .d_i   (job_i.d),
      .q_o   (q[r]),
      .ovf_o (ovf[r])
    );
  end

  always_comb begin
    logic [XW-1:0] lim;
    logic [XW-1:0] mag;
    for (int r = 0; r < 3; r++) begin
      lim     = neg_q[QW][r] ? ls3_pkg::X_MIN : ls3_pkg::X_MAX;
      clip[r] = ovf[r] || (q[r] > lim);
      mag     = clip[r] ? lim : q[r];
      x_d[r]  = solved_q[QW] ? (neg_q[QW][r] ? XW'(-mag) : mag) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[BS-2:0], job_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      neg_q[0]    <= job_i.neg;
      solved_q[0] <= job_i.solved;
      for (int k = 0; k < QW; k++) begin
        neg_q[k+1]    <= neg_q[k];
        solved_q[k+1] <= solved_q[k];
      end
      x_q          <= x_d;
      solved_out_q <= solved_q[QW];
      clipped_q    <= solved_q[QW] && (clip != '0);
    end
  end

  assign out_valid_o = v_q[BS-1];
  assign x_o         = x_q;
  assign solved_o    = solved_out_q;
  assign clipped_o   = clipped_q;

  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !solved_o |-> x_o == '0 && !clipped_o)
    else $error("singular result not zero");

  a_clip_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clipped_o |->
      x_o[0] == ls3_pkg::X_MAX || x_o[0] == ls3_pkg::X_MIN ||
      x_o[1] == ls3_pkg::X_MAX || x_o[1] == ls3_pkg::X_MIN ||
      x_o[2] == ls3_pkg::X_MAX || x_o[2] == ls3_pkg::X_MIN)
    else $error("clipped result without a saturated element");

endmodule
`default_nettype wire

/* sv/linear_system_3x3_solver.sv */
// Top level of the 3x3 linear system solver.
// Solves A x = b for a 3x3 matrix and a 3-vector in signed fixed point
// with FRAC_BITS fraction bits, by cofactors and the determinant.
// Request channel: in_valid_i / in_stall_o with the twelve inputs; a request
// is taken at a clock edge with in_valid_i high and in_stall_o low.
// Result channel: out_valid_o / out_stall_i with x0..x2, solved and clipped.
// Configuration: cfg_valid_i / cfg_ready_o writes singular_tolerance; ready
// is always high. Write only while no request is in flight.
// Throughput is one request per cycle while no stall holds it. The path is
// a 7-stage front (products, cofactors, determinant, numerators), the queue,
// then a 33-stage divider (an input stage and 32 stages of one quotient bit
// each), and the output register. A 4-entry queue parts front and back.
// Reset clears all valid bits and loads the tolerance reset value.
// While out_stall_i is high with a valid result, the back freezes and holds it; the
// front keeps taking requests until the queue fills, then raises in_stall_o.
`timescale 1ns / 1ps
`default_nettype none
module linear_system_3x3_solver #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_stall_o,
  input  wire logic signed [31:0]        a00_i,
  input  wire logic signed [31:0]        a01_i,
  input  wire logic signed [31:0]        a02_i,
  input  wire logic signed [31:0]        a10_i,
  input  wire logic signed [31:0]        a11_i,
  input  wire logic signed [31:0]        a12_i,
  input  wire logic signed [31:0]        a20_i,
  input  wire logic signed [31:0]        a21_i,
  input  wire logic signed [31:0]        a22_i,
  input  wire logic signed [31:0]        b0_i,
  input  wire logic signed [31:0]        b1_i,
  input  wire logic signed [31:0]        b2_i,
  output logic                           out_valid_o,
  input  wire logic                      out_stall_i,
  output logic signed [31:0]             x0_o,
  output logic signed [31:0]             x1_o,
  output logic signed [31:0]             x2_o,
  output logic                           solved_o,
  output logic                           clipped_o,
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic [ls3_pkg::TOL_W-1:0] cfg_data_i
);

  logic [ls3_pkg::TOL_W-1:0]      tol_q;
  logic [8:0][ls3_pkg::IN_W-1:0]  a_mat;
  logic [2:0][ls3_pkg::IN_W-1:0]  b_vec;
  ls3_pkg::ls3_job_t              fj, bj;
  logic                           fj_valid, fj_ready, bj_valid, bj_ready;
  logic [2:0][ls3_pkg::XW-1:0]    x;

  assign a_mat = {a22_i, a21_i, a20_i, a12_i, a11_i, a10_i, a02_i, a01_i, a00_i};
  assign b_vec = {b2_i, b1_i, b0_i};
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= ls3_pkg::TOL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_data_i;
    end
  end

  ls3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .a_i         (a_mat),
    .b_i         (b_vec),
    .tol_i       (tol_q),
    .job_valid_o (fj_valid),
    .job_ready_i (fj_ready),
    .job_o       (fj)
  );

  ls3_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fj_valid),
    .push_ready_o (fj_ready),
    .push_data_i  (fj),
    .pop_valid_o  (bj_valid),
    .pop_ready_i  (bj_ready),
    .pop_data_o   (bj)
  );

  ls3_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (bj_valid),
    .job_ready_o (bj_ready),
    .job_i       (bj),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .x_o         (x),
    .solved_o    (solved_o),
    .clipped_o   (clipped_o)
  );

  assign x0_o = $signed(x[0]);
  assign x1_o = $signed(x[1]);
  assign x2_o = $signed(x[2]);

endmodule
`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for the 3x3 linear system solver.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned TW = ls3_pkg::TOL_W;

  typedef struct packed {
    logic signed [31:0] x0;
    logic signed [31:0] x1;
    logic signed [31:0] x2;
    logic               solved;
    logic               clipped;
  } solution_t;

  class solution_board;
    solution_t pending[$];
    logic [TW-1:0] tol;
    int errors;

    function new();
      tol = ls3_pkg::TOL_RESET;
      errors = 0;
    endfunction

    function void report(string f, logic [31:0] got, logic [31:0] want);
      if (errors < 40) $display("mismatch %s: got %h want %h", f, got, want);
      errors++;
    endfunction

    function logic signed [31:0] div_round(logic signed [127:0] num,
                                           logic signed [127:0] den,
                                           inout logic clip);
      logic neg;
      logic [127:0] mn, md, q, lim;
      logic [31:0] mag;
      neg = num[127] ^ den[127];
      mn = num[127] ? -num : num;
      md = den[127] ? -den : den;
      q = ((mn << 17) + md) / (md << 1);
      lim = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
      if (q > lim) begin
        clip = 1'b1;
        mag = lim[31:0];
      end else begin
        mag = q[31:0];
      end
      return neg ? -mag : mag;
    endfunction

    function void note_request(logic signed [31:0] m[9], logic signed [31:0] v[3]);
      logic signed [127:0] a[9];
      logic signed [127:0] b[3];
      logic signed [127:0] adj[9];
      logic signed [127:0] det, mag, num;
      logic clip;
      solution_t s;
      for (int i = 0; i < 9; i++) a[i] = m[i];
      for (int i = 0; i < 3; i++) b[i] = v[i];
      adj[0] = a[4] * a[8] - a[5] * a[7];
      adj[1] = a[2] * a[7] - a[1] * a[8];
      adj[2] = a[1] * a[5] - a[2] * a[4];
      adj[3] = a[5] * a[6] - a[3] * a[8];
      adj[4] = a[0] * a[8] - a[2] * a[6];
      adj[5] = a[2] * a[3] - a[0] * a[5];
      adj[6] = a[3] * a[7] - a[4] * a[6];
      adj[7] = a[1] * a[6] - a[0] * a[7];
      adj[8] = a[0] * a[4] - a[1] * a[3];
      det = a[0] * adj[0] + a[1] * adj[3] + a[2] * adj[6];
      mag = det[127] ? -det : det;
      s = '0;
      clip = 1'b0;
      if (mag != 0 && mag >= {65'd0, tol}) begin
        num = adj[0] * b[0] + adj[1] * b[1] + adj[2] * b[2];
        s.x0 = div_round(num, det, clip);
        num = adj[3] * b[0] + adj[4] * b[1] + adj[5] * b[2];
        s.x1 = div_round(num, det, clip);
        num = adj[6] * b[0] + adj[7] * b[1] + adj[8] * b[2];
        s.x2 = div_round(num, det, clip);
        s.solved = 1'b1;
        s.clipped = clip;
      end
      pending.push_back(s);
    endfunction

    function void check_result(solution_t got);
      solution_t w;
      if (pending.size() == 0) begin
        report("result with none pending", 32'd1, 32'd0);
        return;
      end
      w = pending.pop_front();
      if (got.x0 !== w.x0) report("x0", got.x0, w.x0);
      if (got.x1 !== w.x1) report("x1", got.x1, w.x1);
      if (got.x2 !== w.x2) report("x2", got.x2, w.x2);
      if (got.solved !== w.solved) report("solved", got.solved, w.solved);
      if (got.clipped !== w.clipped) report("clipped", got.clipped, w.clipped);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] a_q[9];
  logic signed [31:0] b_q[3];
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] x0_o, x1_o, x2_o;
  logic solved_o, clipped_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [TW-1:0] cfg_data_i = '0;

  solution_board board;
  int send_idle = 0;
  int stall_pct = 0;
  int hold_off = 0;

  always #10 clk_i = ~clk_i;

  initial begin
    for (int i = 0; i < 9; i++) a_q[i] = '0;
    for (int i = 0; i < 3; i++) b_q[i] = '0;
  end

  linear_system_3x3_solver i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o,
    .a00_i(a_q[0]), .a01_i(a_q[1]), .a02_i(a_q[2]),
    .a10_i(a_q[3]), .a11_i(a_q[4]), .a12_i(a_q[5]),
    .a20_i(a_q[6]), .a21_i(a_q[7]), .a22_i(a_q[8]),
    .b0_i(b_q[0]), .b1_i(b_q[1]), .b2_i(b_q[2]),
    .out_valid_o, .out_stall_i, .x0_o, .x1_o, .x2_o, .solved_o, .clipped_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result('{x0_o, x1_o, x2_o, solved_o, clipped_o});
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_system(logic signed [31:0] m[9], logic signed [31:0] v[3]);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    for (int i = 0; i < 9; i++) a_q[i] <= m[i];
    for (int i = 0; i < 3; i++) b_q[i] <= v[i];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_request(m, v);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [TW-1:0] t);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= t;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    board.tol = t;
  endtask

  function automatic logic signed [31:0] rand_elem(int kind);
    case (kind)
      0: return $urandom;
      1: return $signed($urandom_range(8 * 65536)) - 4 * 65536;
      2: return $signed($urandom_range(255)) - 128;
      3: return ($urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000);
      default: return ($signed($urandom_range(20)) - 10) <<< 16;
    endcase
  endfunction

  task automatic send_random();
    logic signed [31:0] m[9];
    logic signed [31:0] v[3];
    int kind, r;
    kind = $urandom_range(4);
    for (int i = 0; i < 9; i++)
      m[i] = ($urandom_range(9) == 0) ? rand_elem($urandom_range(4)) : rand_elem(kind);
    for (int i = 0; i < 3; i++) v[i] = rand_elem($urandom_range(4));
    r = $urandom_range(9);
    if (r == 0) for (int i = 0; i < 3; i++) m[3 + i] = m[i];
    if (r == 1) for (int i = 0; i < 3; i++) m[6 + i] = m[i] + m[3 + i];
    send_system(m, v);
  endtask

  task automatic send_directed();
    logic signed [31:0] m[9];
    logic signed [31:0] v[3];
    int one;
    one = 65536;
    m = '{one, 0, 0, 0, one, 0, 0, 0, one}; v = '{one, -one, 3 * one};
    send_system(m, v);
    m = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
    send_system(m, v);
    m = '{2, 0, 0, 0, 2, 0, 0, 0, 2};
    send_system(m, v);
    m = '{one, 0, 0, 0, one, 0, 0, 0, 1}; v = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
    send_system(m, v);
    m = '{32'sh8000_0000, 0, 0, 0, 32'sh8000_0000, 0, 0, 0, 32'sh8000_0000};
    send_system(m, v);
    m = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
          32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000};
    send_system(m, v);
    m = '{3 * one, 0, 0, 0, 3 * one, 0, 0, 0, 3 * one}; v = '{one, -one, 2};
    send_system(m, v);
    m = '{-1, -1, -1, -1, -1, -1, -1, -1, -1}; v = '{-1, -1, -1};
    send_system(m, v);
    m = '{one, one, 0, one, one + 1, 0, 0, 0, one}; v = '{one, 0, -one};
    send_system(m, v);
    m = '{-2 * one, 0, 0, 0, -2 * one, 0, 0, 0, -2 * one}; v = '{1, -1, 3};
    send_system(m, v);
  endtask

  initial begin
    board = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_directed();
    drain();
    write_tolerance('0);
    send_directed();
    drain();
    write_tolerance({TW{1'b1}});
    send_directed();
    repeat (20) send_random();
    drain();
    write_tolerance(TW'(1) << 40);
    for (int p = 0; p < 4; p++) begin
      send_idle = (p == 1 || p == 3) ? ((p == 1) ? 74 : 31) : 0;
      stall_pct = (p == 2) ? 74 : ((p == 3) ? 31 : 0);
      for (int i = 0; i < 300; i++) send_random();
      drain();
      write_tolerance(p[0] ? ls3_pkg::TOL_RESET :
                      TW'({$urandom, $urandom} >> ($urandom_range(63) + 1)));
    end
    send_idle = 0;
    stall_pct = 20;
    hold_off = 300;
    for (int i = 0; i < 300; i++) send_random();
    drain();
    write_tolerance(ls3_pkg::TOL_RESET);
    for (int i = 0; i < 300; i++) send_random();
    drain();
    if (board.errors == 0) begin
      $display("PASS linear_system_3x3_solver");
    end else begin
      $display("FAIL linear_system_3x3_solver");
    end
    $finish;
  end

  initial begin
    #(20ns * 400000);
    $display("FAIL linear_system_3x3_solver");
    $finish;
  end
endmodule
